>>> hw/rtl/lz4_block_decompressor_macros.svh
// Assertion macros used by the lz4 block decompressor checker.
`ifndef LZ4_BLOCK_DECOMPRESSOR_MACROS_SVH
`define LZ4_BLOCK_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LZBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lz4 decompressor check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LZBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lz4 decompressor check failed");

`endif

>>> hw/rtl/lzbd_pkg.sv
// ----------------------------------------------------------------------------
// lzbd_pkg
// Types and constants shared by the LZ4 block decompressor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lzbd_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [3:0] NIB_EXT    = 4'hF;
    localparam logic [7:0] BYTE_EXT   = 8'hFF;
    localparam logic [3:0] MATCH_BIAS = 4'd4;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_REFUSED = 3'd1,
        ST_IDLE    = 3'd2,
        ST_BADOFF  = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_OVER    = 3'd5,
        ST_DISCARD = 3'd6
    } status_t;

    // Input word
    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    // Result word
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        status_t    status;
        logic       copy_pending;
        logic       block_done;
    } result_t;

    // Classified operation from parser to history engine
    typedef struct packed {
        logic              writes;
        logic              is_copy;
        logic [7:0]        lit;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] wr_addr;
        status_t           status;
        logic              pending;
        logic              done;
    } op_t;

endpackage

`default_nettype wire

>>> hw/rtl/lzbd_front.sv
// ----------------------------------------------------------------------------
// lzbd_front
// Sequence parser: takes one word per cycle while the queue is not full, tracks
// the token, lengths and offset, and emits one classified operation per word.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbd_front
    import lzbd_pkg::*;
#(
    parameter int unsigned HISTORY_BYTES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       push,
    output op_t        op,
    input  wire logic  full
);

    localparam int unsigned AW  = $clog2(HISTORY_BYTES);
    localparam int unsigned PCW = $clog2(HISTORY_BYTES + 1);
    localparam logic [AW-1:0]  WP_LAST = AW'(HISTORY_BYTES - 1);
    localparam logic [PCW-1:0] PC_MAX  = PCW'(HISTORY_BYTES);
    localparam logic [16:0]    H_X     = 17'(HISTORY_BYTES);

    typedef enum logic [2:0] {
        PH_TOKEN = 3'd0,
        PH_LEXT  = 3'd1,
        PH_LIT   = 3'd2,
        PH_OLO   = 3'd3,
        PH_OHI   = 3'd4,
        PH_MEXT  = 3'd5,
        PH_DROP  = 3'd6
    } phase_t;

    phase_t             ph_reg, ph_next;
    logic [LEN_W-1:0]   lr_reg, lr_next;
    logic [LEN_W-1:0]   mr_reg, mr_next;
    logic [3:0]         mn_reg, mn_next;
    logic [15:0]        mo_reg, mo_next;
    logic               ls_reg, ls_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [PCW-1:0]     pc_reg, pc_next;

    logic               accept;
    logic               pending;
    logic               put;
    logic               drop;
    logic [16:0]        off_x;
    logic [16:0]        wp_x;
    logic [16:0]        src_x;
    logic               bad_off;
    logic [LEN_W:0]     lext_sum;
    logic [LEN_W:0]     mext_sum;
    logic [LEN_W+1:0]   mend_sum;
    logic [LEN_W-1:0]   lr_dec;

    assign item_stall = full;
    assign accept     = item_valid && !full;
    assign push       = accept;
    assign pending    = (mr_reg != '0) && (ph_reg != PH_MEXT);

    // Offset and copy source
    assign off_x   = {1'b0, item.in_byte, mo_reg[7:0]};
    assign wp_x    = 17'(wp_reg);
    assign src_x   = (wp_x >= 17'(mo_reg)) ? (wp_x - 17'(mo_reg))
                                           : (wp_x + H_X - 17'(mo_reg));
    assign bad_off = (off_x == '0) || (off_x > 17'(pc_reg));

    // Saturating length arithmetic
    assign lext_sum = {1'b0, lr_reg} + (LEN_W + 1)'(item.in_byte);
    assign mext_sum = {1'b0, mr_reg} + (LEN_W + 1)'(item.in_byte);
    assign mend_sum = {2'b00, mr_reg} + (LEN_W + 2)'(item.in_byte)
                      + (LEN_W + 2)'(MATCH_BIAS);
    assign lr_dec   = (lr_reg != '0) ? (lr_reg - LEN_W'(1)) : '0;

    // Classify the word and compute the next parse state
    always_comb
    begin
        ph_next = ph_reg;
        lr_next = lr_reg;
        mr_next = mr_reg;
        mn_next = mn_reg;
        mo_next = mo_reg;
        ls_next = ls_reg;
        wp_next = wp_reg;
        pc_next = pc_reg;
        put     = 1'b0;
        drop    = 1'b0;
        op         = '0;
        op.wr_addr = ADDR_W'(wp_reg);
        op.status  = ST_OK;

        if (item.command)
        begin
            if (!pending)
            begin
                op.status = ST_IDLE;
            end
            else
            begin
                put        = 1'b1;
                op.writes  = 1'b1;
                op.is_copy = 1'b1;
                op.src     = ADDR_W'(src_x);
                mr_next    = mr_reg - LEN_W'(1);
                if ((mr_reg == LEN_W'(1)) && ls_reg)
                    op.done = 1'b1;
            end
        end
        else if (pending)
        begin
            op.status = ST_REFUSED;
        end
        else
        begin
            unique case (ph_reg)
                PH_TOKEN:
                begin
                    mn_next = item.in_byte[3:0];
                    if (item.in_byte[7:4] == NIB_EXT)
                    begin
                        lr_next = LEN_W'(NIB_EXT);
                        ph_next = PH_LEXT;
                        if (item.in_last)
                            op.status = ST_TRUNC;
                    end
                    else if (item.in_byte[7:4] != 4'd0)
                    begin
                        lr_next = LEN_W'(item.in_byte[7:4]);
                        ph_next = PH_LIT;
                        if (item.in_last)
                            op.status = ST_TRUNC;
                    end
                    else if (item.in_last)
                        op.done = 1'b1;
                    else
                        ph_next = PH_OLO;
                end
                PH_LEXT:
                begin
                    lr_next = lext_sum[LEN_W] ? '1 : lext_sum[LEN_W-1:0];
                    if (lext_sum[LEN_W] && !item.in_last)
                        op.status = ST_OVER;
                    if (item.in_last)
                        op.status = ST_TRUNC;
                    else if (item.in_byte != BYTE_EXT)
                        ph_next = PH_LIT;
                end
                PH_LIT:
                begin
                    put       = 1'b1;
                    op.writes = 1'b1;
                    op.lit    = item.in_byte;
                    lr_next   = lr_dec;
                    if (lr_dec == '0)
                    begin
                        if (item.in_last)
                            op.done = 1'b1;
                        else
                            ph_next = PH_OLO;
                    end
                    else if (item.in_last)
                        op.status = ST_TRUNC;
                end
                PH_OLO:
                begin
                    mo_next = {8'h00, item.in_byte};
                    if (item.in_last)
                        op.status = ST_TRUNC;
                    else
                        ph_next = PH_OHI;
                end
                PH_OHI:
                begin
                    if (bad_off)
                    begin
                        op.status = ST_BADOFF;
                        if (item.in_last)
                            op.done = 1'b1;
                        else
                            drop = 1'b1;
                    end
                    else
                    begin
                        mo_next = off_x[15:0];
                        if (mn_reg == NIB_EXT)
                        begin
                            if (item.in_last)
                                op.status = ST_TRUNC;
                            else
                            begin
                                mr_next = LEN_W'(NIB_EXT);
                                ph_next = PH_MEXT;
                            end
                        end
                        else
                        begin
                            mr_next = LEN_W'(mn_reg) + LEN_W'(MATCH_BIAS);
                            ph_next = PH_TOKEN;
                            if (item.in_last)
                                ls_next = 1'b1;
                        end
                    end
                end
                PH_MEXT:
                begin
                    if (item.in_byte != BYTE_EXT)
                    begin
                        mr_next = (mend_sum[LEN_W+1:LEN_W] != 2'b00)
                                  ? '1 : mend_sum[LEN_W-1:0];
                        if (mend_sum[LEN_W+1:LEN_W] != 2'b00)
                            op.status = ST_OVER;
                        ph_next = PH_TOKEN;
                        if (item.in_last)
                            ls_next = 1'b1;
                    end
                    else
                    begin
                        mr_next = mext_sum[LEN_W] ? '1 : mext_sum[LEN_W-1:0];
                        if (mext_sum[LEN_W])
                            op.status = ST_OVER;
                        if (item.in_last)
                            op.status = ST_TRUNC;
                    end
                end
                default:
                begin
                    op.status = ST_DISCARD;
                    if (item.in_last)
                        op.done = 1'b1;
                end
            endcase
            if (op.status == ST_TRUNC)
                op.done = 1'b1;
        end

        // Advance write pointer and produced count
        if (put)
        begin
            wp_next = (wp_reg == WP_LAST) ? '0 : (wp_reg + AW'(1));
            if (pc_reg < PC_MAX)
                pc_next = pc_reg + PCW'(1);
        end

        // Clear parse state at block end or when a bad offset drops the block
        if (op.done || drop)
        begin
            ph_next = drop ? PH_DROP : PH_TOKEN;
            lr_next = '0;
            mr_next = '0;
            mn_next = '0;
            mo_next = '0;
            ls_next = 1'b0;
            pc_next = '0;
        end

        op.pending = (mr_next != '0) && (ph_next != PH_MEXT);
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_TOKEN;
            lr_reg <= '0;
            mr_reg <= '0;
            mn_reg <= '0;
            mo_reg <= '0;
            ls_reg <= 1'b0;
            wp_reg <= '0;
            pc_reg <= '0;
        end
        else if (accept)
        begin
            ph_reg <= ph_next;
            lr_reg <= lr_next;
            mr_reg <= mr_next;
            mn_reg <= mn_next;
            mo_reg <= mo_next;
            ls_reg <= ls_next;
            wp_reg <= wp_next;
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lzbd_queue.sv
// ----------------------------------------------------------------------------
// lzbd_queue
// Small FIFO of classified operations between parser and history engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbd_queue
    import lzbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  din,
    output logic      full,
    input  wire logic pop,
    output op_t       dout,
    output logic      empty
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       count_reg;

    assign full  = (count_reg == (PW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    // Store pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PW + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PW + 1)'(1);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lzbd_back.sv
// ----------------------------------------------------------------------------
// lzbd_back
// History engine: reads match bytes from the history memory, writes every
// produced byte back, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lzbd_back
    import lzbd_pkg::*;
#(
    parameter int unsigned HISTORY_BYTES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire op_t   head,
    input  wire logic  empty,
    output logic       pop,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    localparam int unsigned AW = $clog2(HISTORY_BYTES);

    logic [7:0]  hist_mem [HISTORY_BYTES];
    logic        w_valid_reg;
    op_t         w_op_reg;
    logic [7:0]  mem_q_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_byte_reg;
    logic        en;
    logic        hit;
    logic [7:0]  w_byte;

    assign en  = !w_valid_reg || !result_stall;
    assign pop = en && !empty;

    // Catch a read of the byte still being written by the word ahead
    assign hit = w_valid_reg && w_op_reg.writes
                 && (w_op_reg.wr_addr[AW-1:0] == head.src[AW-1:0]);

    assign w_byte = w_op_reg.is_copy ? (fwd_reg ? fwd_byte_reg : mem_q_reg)
                                     : w_op_reg.lit;

    // History memory: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (w_valid_reg && w_op_reg.writes)
            hist_mem[w_op_reg.wr_addr[AW-1:0]] <= w_byte;
        if (pop)
        begin
            mem_q_reg    <= hist_mem[head.src[AW-1:0]];
            fwd_reg      <= hit;
            fwd_byte_reg <= w_byte;
            w_op_reg     <= head;
        end
    end

    // Hold output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_valid_reg <= 1'b0;
        else if (en)
            w_valid_reg <= !empty;
    end

    // Drive result word
    always_comb
    begin
        result_valid        = w_valid_reg;
        result.out_valid    = w_op_reg.writes;
        result.out_byte     = w_op_reg.writes ? w_byte : 8'h00;
        result.status       = w_op_reg.status;
        result.copy_pending = w_op_reg.pending;
        result.block_done   = w_op_reg.done;
    end

endmodule

`default_nettype wire

>>> hw/rtl/lz4_block_decompressor.sv
// ----------------------------------------------------------------------------
// lz4_block_decompressor
// LZ4 block decompressor with a byte-wide compressed input and one result
// word per input word.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless item_stall is high and returns one result
// word per input word, in order, through the queue and the result register.
// A word is either a compressed byte (command 0) or a copy tick (command 1)
// that emits the next match byte from the history; a byte offered while a
// copy is still pending is answered with a refused status. The sustained
// rate is one word per cycle without output stalls, set by the single read
// and single write port of the HISTORY_BYTES-deep history memory; a four-word
// queue separates the parser from the history engine. History contents are
// undefined after reset and only bytes of the current block are ever read.
`default_nettype none

module lz4_block_decompressor
    import lzbd_pkg::*;
#(
    parameter int unsigned HISTORY_BYTES = 65536
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    op_t  push_op;
    op_t  head_op;
    logic push;
    logic pop;
    logic full;
    logic empty;

    lzbd_front #(
        .HISTORY_BYTES(HISTORY_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item      (item),
        .push      (push),
        .op        (push_op),
        .full      (full)
    );

    lzbd_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (push_op),
        .full (full),
        .pop  (pop),
        .dout (head_op),
        .empty(empty)
    );

    lzbd_back #(
        .HISTORY_BYTES(HISTORY_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_op),
        .empty       (empty),
        .pop         (pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lzbd_checker.sv
// ----------------------------------------------------------------------------
// lzbd_checker
// Port-level checks for the LZ4 block decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lz4_block_decompressor_macros.svh"

module lzbd_checker
    import lzbd_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // Stalled result word holds
    `LZBD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, $stable(result))

    // No byte means a zero byte
    `LZBD_ASSERT_NOW(a_zero_byte, result_valid && !result.out_valid,
        result.out_byte == 8'h00)

    // Idle tick produces nothing and leaves no copy pending
    `LZBD_ASSERT_NOW(a_idle_quiet, result_valid && (result.status == ST_IDLE),
        !result.out_valid && !result.copy_pending && !result.block_done)

    // Refused byte keeps the copy pending
    `LZBD_ASSERT_NOW(a_refused_pending, result_valid && (result.status == ST_REFUSED),
        result.copy_pending && !result.out_valid && !result.block_done)

    // Block end leaves no match bytes behind
    `LZBD_ASSERT_NOW(a_done_clear, result_valid && result.block_done,
        !result.copy_pending)

endmodule

bind lz4_block_decompressor lzbd_checker u_lzbd_checker (.*);

`default_nettype wire
